// ----- src/hbs_pkg.sv -----
// Shared constants and types for the 3x3 height map smoothing block.
// Used by the top level and by its port checker; depends on nothing.
package hbs_pkg;

   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 16;
   localparam int COORD_W       = 16;
   localparam int REGION_W_BITS = 11;

   typedef logic [COORD_W-1:0]   coord_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type REG_MAP_SIZE      = 3'd0;
   localparam csr_idx_type REG_START_COL     = 3'd1;
   localparam csr_idx_type REG_START_ROW     = 3'd2;
   localparam csr_idx_type REG_REGION_WIDTH  = 3'd3;
   localparam csr_idx_type REG_REGION_HEIGHT = 3'd4;

endpackage

// ----- src/hbs_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// A read of the address being written returns the old contents. No dependencies.
module hbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/heightmap_box_smooth_3x3.sv -----
// 3x3 box smoothing of a clamped region of a square height map, one request per cycle
// while not stalled. A result passes the input, window, divide and output registers.
// The rate is set by the two line memories (one read, one write each).
// A configuration write holds off requests in the cycle after it while the geometry is rebuilt.
// Reset is synchronous: it clears the registers, counters and pipeline, not the line memories.
// Depends on hbs_pkg and hbs_ram.
module heightmap_box_smooth_3x3 #(
   parameter int MAX_WIDTH   = 1024,
   parameter int HEIGHT_BITS = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [HEIGHT_BITS-1:0]     req_height_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [HEIGHT_BITS-1:0]     rsp_smoothed_height,
   output hbs_pkg::coord_type                rsp_out_col,
   output hbs_pkg::coord_type                rsp_out_row,
   output logic                              rsp_last_out,
   input  logic                              csr_wr_en,
   input  hbs_pkg::csr_idx_type              csr_index,
   input  logic [hbs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CW    = HEIGHT_BITS + 2;
   localparam int SW    = HEIGHT_BITS + 4;
   localparam int SHIFT = SW + 3;
   localparam int MW    = SW + 1;
   localparam int PW    = SW + MW;
   localparam int GW    = hbs_pkg::COORD_W + 1;
   localparam logic [MW-1:0] RECIP = MW'(((64'd1 << SHIFT) + 64'd8) / 64'd9);

   // Configuration registers.
   hbs_pkg::coord_type                   map_size_ff, start_col_ff, start_row_ff;
   hbs_pkg::coord_type                   region_height_ff;
   logic [hbs_pkg::REGION_W_BITS-1:0]    region_width_ff;
   logic                                 cfg_pend_ff;
   logic                                 cfg_hit;

   assign cfg_hit = csr_wr_en && (csr_index <= hbs_pkg::REG_REGION_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         map_size_ff      <= '0;
         start_col_ff     <= '0;
         start_row_ff     <= '0;
         region_width_ff  <= '0;
         region_height_ff <= '0;
         cfg_pend_ff      <= 1'b0;
      end else begin
         cfg_pend_ff <= csr_wr_en;
         if (csr_wr_en) begin
            case (csr_index)
               hbs_pkg::REG_MAP_SIZE:      map_size_ff      <= csr_wdata;
               hbs_pkg::REG_START_COL:     start_col_ff     <= csr_wdata;
               hbs_pkg::REG_START_ROW:     start_row_ff     <= csr_wdata;
               hbs_pkg::REG_REGION_WIDTH:
                  region_width_ff <= csr_wdata[hbs_pkg::REGION_W_BITS-1:0];
               hbs_pkg::REG_REGION_HEIGHT: region_height_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Effective region, clamped to the map edge; the width also to the line memory depth.
   logic [GW-1:0]      col_room, row_room, ew_lim, eh_lim;
   logic               geom_ok_in;
   logic               geom_ok_ff;
   logic [WW-1:0]      width_ff;
   hbs_pkg::coord_type height_ff;

   always_comb begin
      col_room = GW'(map_size_ff) - GW'(start_col_ff);
      row_room = GW'(map_size_ff) - GW'(start_row_ff);
      ew_lim   = GW'(region_width_ff);
      if (col_room < ew_lim) begin
         ew_lim = col_room;
      end
      if (GW'(MAX_WIDTH) < ew_lim) begin
         ew_lim = GW'(MAX_WIDTH);
      end
      eh_lim = GW'(region_height_ff);
      if (row_room < eh_lim) begin
         eh_lim = row_room;
      end
      geom_ok_in = (map_size_ff != '0) && (start_col_ff < map_size_ff)
                   && (start_row_ff < map_size_ff) && (ew_lim != '0) && (eh_lim != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ok_ff <= 1'b0;
      end else begin
         geom_ok_ff <= geom_ok_in;
      end
      width_ff  <= ew_lim[WW-1:0];
      height_ff <= eh_lim[hbs_pkg::COORD_W-1:0];
   end

   // Pipeline flow control.
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic en1, en2, en3, en_out;
   logic accept, take;

   assign en_out    = !rsp_valid_ff || rsp_ready;
   assign en3       = !v3_ff || en_out;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_ready = en1 && !cfg_pend_ff && !reset;
   assign accept    = req_valid && req_ready;
   assign take      = accept && geom_ok_ff;

   // Position of the incoming sample within the region.
   logic [AW-1:0]      col_ff, col_cur, col_in;
   hbs_pkg::coord_type row_ff, row_cur, row_in;
   logic               wrap, col_last, row_last, emit;
   hbs_pkg::coord_type out_col_cur, out_row_cur;

   always_comb begin
      wrap     = (WW'(col_ff) >= width_ff) || (row_ff >= height_ff);
      col_cur  = wrap ? '0 : col_ff;
      row_cur  = wrap ? '0 : row_ff;
      col_last = (WW'(col_cur) == width_ff - WW'(1));
      row_last = (row_cur == height_ff - 16'd1);
      emit     = (row_cur >= 16'd2) && (col_cur >= AW'(2));
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : row_cur + 16'd1;
      end else begin
         col_in = col_cur + AW'(1);
         row_in = row_cur;
      end
      out_col_cur = start_col_ff + hbs_pkg::COORD_W'(col_cur) - 16'd1;
      out_row_cur = start_row_ff + row_cur - 16'd1;
   end

   always_ff @(posedge clock) begin
      if (reset || cfg_hit) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (take) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line memories: one holds the row above, the other the row two above.
   logic [AW-1:0]                    addr1_ff;
   logic signed [HEIGHT_BITS-1:0]    x1_ff, a_s1, b_s1;
   logic [HEIGHT_BITS-1:0]           above_rdata, two_rdata;
   logic                             wr1;

   assign wr1 = v1_ff && en2;

   hbs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_row_above (
      .clock (clock),
      .we    (wr1),
      .waddr (addr1_ff),
      .wdata (x1_ff),
      .re    (take),
      .raddr (col_cur),
      .rdata (above_rdata)
   );

   hbs_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(MAX_WIDTH)) u_row_two_above (
      .clock (clock),
      .we    (wr1),
      .waddr (addr1_ff),
      .wdata (b_s1),
      .re    (take),
      .raddr (col_cur),
      .rdata (two_rdata)
   );

   // A one-column region reads the entry that the previous sample is writing in the
   // same cycle; the memory returns stale data, so the new values are forwarded.
   logic                          fwd_ff;
   logic signed [HEIGHT_BITS-1:0] fwd_a_ff, fwd_b_ff;
   logic                          emit1_ff, last1_ff;
   hbs_pkg::coord_type            col1_ff, row1_ff;

   assign a_s1 = fwd_ff ? fwd_a_ff : $signed(two_rdata);
   assign b_s1 = fwd_ff ? fwd_b_ff : $signed(above_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= take;
      end
      if (take) begin
         addr1_ff <= col_cur;
         x1_ff    <= req_height_in;
         emit1_ff <= emit;
         last1_ff <= col_last && row_last;
         col1_ff  <= out_col_cur;
         row1_ff  <= out_row_cur;
         fwd_ff   <= v1_ff && (addr1_ff == col_cur);
         fwd_a_ff <= b_s1;
         fwd_b_ff <= x1_ff;
      end
   end

   // Window: column sums of the two previous columns plus the current one.
   logic signed [CW-1:0] colsum, cs1_ff, cs2_ff;
   logic signed [SW-1:0] total, total2_ff;
   logic                 last2_ff;
   hbs_pkg::coord_type   col2_ff, row2_ff;

   assign colsum = CW'(a_s1) + CW'(b_s1) + CW'(x1_ff);
   assign total  = SW'(colsum) + SW'(cs1_ff) + SW'(cs2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff && emit1_ff;
      end
      if (wr1) begin
         cs1_ff    <= colsum;
         cs2_ff    <= cs1_ff;
         total2_ff <= total;
         last2_ff  <= last1_ff;
         col2_ff   <= col1_ff;
         row2_ff   <= row1_ff;
      end
   end

   // Divide by nine, rounded to nearest: q = floor((|sum| + 4) / 9), done as a
   // multiplication by the rounded-up reciprocal and a shift.
   logic          neg2;
   logic [SW-1:0] mag2, bias2;
   logic [PW-1:0] prod, prod3_ff;
   logic          neg3_ff, last3_ff;
   hbs_pkg::coord_type col3_ff, row3_ff;

   assign neg2  = total2_ff[SW-1];
   assign mag2  = neg2 ? SW'(-total2_ff) : SW'(total2_ff);
   assign bias2 = mag2 + SW'(4);
   assign prod  = PW'(bias2) * PW'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en3) begin
         v3_ff <= v2_ff;
      end
      if (en3 && v2_ff) begin
         prod3_ff <= prod;
         neg3_ff  <= neg2;
         last3_ff <= last2_ff;
         col3_ff  <= col2_ff;
         row3_ff  <= row2_ff;
      end
   end

   logic [HEIGHT_BITS-1:0]        quot3;
   logic signed [HEIGHT_BITS-1:0] mean3, mean_ff;
   logic                          last_ff;
   hbs_pkg::coord_type            ocol_ff, orow_ff;

   assign quot3 = prod3_ff[SHIFT +: HEIGHT_BITS];
   assign mean3 = neg3_ff ? $signed(-quot3) : $signed(quot3);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en_out) begin
         rsp_valid_ff <= v3_ff;
      end
      if (en_out && v3_ff) begin
         mean_ff <= mean3;
         last_ff <= last3_ff;
         ocol_ff <= col3_ff;
         orow_ff <= row3_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_smoothed_height = mean_ff;
   assign rsp_out_col         = ocol_ff;
   assign rsp_out_row         = orow_ff;
   assign rsp_last_out        = last_ff;

endmodule

// ----- src/hbs_checker.sv -----
// Port-level checks for the 3x3 height map smoothing block, bound to its top level.
// Depends on hbs_pkg and heightmap_box_smooth_3x3.
module hbs_checker #(
   parameter int HEIGHT_BITS = 24
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [HEIGHT_BITS-1:0]         rsp_smoothed_height,
   input hbs_pkg::coord_type             rsp_out_col,
   input hbs_pkg::coord_type             rsp_out_row,
   input logic                           rsp_last_out,
   input logic                           csr_wr_en
);

   // A stalled result must hold until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smoothed_height)
         && $stable(rsp_out_col) && $stable(rsp_out_row) && $stable(rsp_last_out))
      else $error("stalled result changed or dropped");

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A register write blocks requests for the next cycle while geometry settles.
   assert property (@(posedge clock) disable iff (reset) csr_wr_en |=> !req_ready)
      else $error("request taken with stale geometry");

   // No request is taken during reset.
   assert property (@(posedge clock) reset |-> !(req_valid && req_ready))
      else $error("request accepted during reset");

endmodule

bind heightmap_box_smooth_3x3 hbs_checker #(.HEIGHT_BITS(HEIGHT_BITS)) u_hbs_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_smoothed_height (rsp_smoothed_height),
   .rsp_out_col         (rsp_out_col),
   .rsp_out_row         (rsp_out_row),
   .rsp_last_out        (rsp_last_out),
   .csr_wr_en           (csr_wr_en)
);

// ----- test/hbs_smooth_checker.sv -----
// Port checker for the 3x3 height map smoothing block: predicts every smoothed sample
// from the observed requests and register writes and compares the responses in order.
// Depends on hbs_pkg.
module hbs_smooth_checker #(
   parameter int MAX_WIDTH   = 1024,
   parameter int HEIGHT_BITS = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic signed [HEIGHT_BITS-1:0]  req_height_in,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic signed [HEIGHT_BITS-1:0]  rsp_smoothed_height,
   input  hbs_pkg::coord_type             rsp_out_col,
   input  hbs_pkg::coord_type             rsp_out_row,
   input  logic                           rsp_last_out,
   input  logic                           csr_wr_en,
   input  hbs_pkg::csr_idx_type           csr_index,
   input  logic [hbs_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatches,
   output int                             outstanding,
   output int                             live_requests,
   output int                             results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      hbs_pkg::coord_type     col;
      hbs_pkg::coord_type     row;
      logic                   last;
   } smoothed_point_type;

   smoothed_point_type expected_points[$];

   int map_side, first_col, first_row, span_cols, span_rows;
   int col_pos, row_pos;
   logic signed [HEIGHT_BITS-1:0] line_above     [MAX_WIDTH];
   logic signed [HEIGHT_BITS-1:0] line_two_above [MAX_WIDTH];
   logic signed [HEIGHT_BITS-1:0] window_cols    [6];

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      live_requests = 0;
      results_seen  = 0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
         line_above[i]     = '0;
         line_two_above[i] = '0;
      end
   end

   task automatic restart_walk();
      for (int i = 0; i < 6; i++) window_cols[i] = '0;
      col_pos = 0;
      row_pos = 0;
   endtask

   // Advances the region walk by one height sample and queues the smoothed point it yields.
   task automatic take_sample(input logic signed [HEIGHT_BITS-1:0] sample);
      int cols, rows, sum, mag, quot;
      logic signed [HEIGHT_BITS-1:0] two_up, one_up;
      smoothed_point_type point;
      if (map_side == 0 || first_col >= map_side || first_row >= map_side) return;
      cols = span_cols;
      if (cols > map_side - first_col) cols = map_side - first_col;
      if (cols > MAX_WIDTH) cols = MAX_WIDTH;
      rows = span_rows;
      if (rows > map_side - first_row) rows = map_side - first_row;
      if (cols == 0 || rows == 0) return;
      live_requests++;
      if (col_pos >= cols || row_pos >= rows) restart_walk();

      two_up = line_two_above[col_pos];
      one_up = line_above[col_pos];
      line_two_above[col_pos] = one_up;
      line_above[col_pos]     = sample;

      if (row_pos >= 2 && col_pos >= 2) begin
         sum = int'(two_up) + int'(one_up) + int'(sample);
         for (int i = 0; i < 6; i++) sum += int'(window_cols[i]);
         mag  = (sum < 0) ? -sum : sum;
         quot = (mag * 2 + 9) / 18;
         point.height = HEIGHT_BITS'((sum < 0) ? -quot : quot);
         point.col    = hbs_pkg::COORD_W'(first_col + col_pos - 1);
         point.row    = hbs_pkg::COORD_W'(first_row + row_pos - 1);
         point.last   = (row_pos == rows - 1) && (col_pos == cols - 1);
         expected_points.push_back(point);
      end

      window_cols[0] = window_cols[3];
      window_cols[1] = window_cols[4];
      window_cols[2] = window_cols[5];
      window_cols[3] = two_up;
      window_cols[4] = one_up;
      window_cols[5] = sample;

      col_pos++;
      if (col_pos == cols) begin
         col_pos = 0;
         row_pos++;
         if (row_pos == rows) row_pos = 0;
      end
   endtask

   always @(posedge clock) begin : watch
      smoothed_point_type want;
      if (reset) begin
         map_side  = 0;
         first_col = 0;
         first_row = 0;
         span_cols = 0;
         span_rows = 0;
         restart_walk();
         expected_points.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               hbs_pkg::REG_MAP_SIZE: begin
                  map_side = int'(csr_wdata);
                  restart_walk();
               end
               hbs_pkg::REG_START_COL: begin
                  first_col = int'(csr_wdata);
                  restart_walk();
               end
               hbs_pkg::REG_START_ROW: begin
                  first_row = int'(csr_wdata);
                  restart_walk();
               end
               hbs_pkg::REG_REGION_WIDTH: begin
                  span_cols = int'(csr_wdata[hbs_pkg::REGION_W_BITS-1:0]);
                  restart_walk();
               end
               hbs_pkg::REG_REGION_HEIGHT: begin
                  span_rows = int'(csr_wdata);
                  restart_walk();
               end
               default: ;
            endcase
         end

         if (req_valid && req_ready) take_sample(req_height_in);

         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected response: height %0d col %0d row %0d last %0b",
                        $time, rsp_smoothed_height, rsp_out_col, rsp_out_row, rsp_last_out);
               mismatches++;
            end else begin
               want = expected_points.pop_front();
               if (rsp_smoothed_height !== want.height) begin
                  $display("%0t: smoothed_height expected %0d, got %0d",
                           $time, $signed(want.height), rsp_smoothed_height);
                  mismatches++;
               end
               if (rsp_out_col !== want.col) begin
                  $display("%0t: out_col expected %0d, got %0d", $time, want.col, rsp_out_col);
                  mismatches++;
               end
               if (rsp_out_row !== want.row) begin
                  $display("%0t: out_row expected %0d, got %0d", $time, want.row, rsp_out_row);
                  mismatches++;
               end
               if (rsp_last_out !== want.last) begin
                  $display("%0t: last_out expected %0b, got %0b",
                           $time, want.last, rsp_last_out);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_points.size();
   end

endmodule

// ----- test/heightmap_box_smooth_3x3_tb.sv -----
// Top of the testbench for heightmap_box_smooth_3x3: clock, reset, region programming,
// height request stimulus with random idling, and the verdict.
// Depends on hbs_pkg, the block itself and hbs_smooth_checker.
module heightmap_box_smooth_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HB             = 24;
   localparam int LINE_MAX       = 1024;
   localparam int ITEMS          = 950;
   localparam int CALM_TAIL      = 150;
   localparam int HOLD_CYCLES    = 400;
   localparam int PRESS_COLS     = 100;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam logic [HB-1:0] HEIGHT_MAX = {1'b0, {(HB-1){1'b1}}};
   localparam logic [HB-1:0] HEIGHT_MIN = {1'b1, {(HB-1){1'b0}}};
   localparam hbs_pkg::csr_idx_type FIRST_UNUSED_REG = hbs_pkg::REG_REGION_HEIGHT + 3'd1;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic signed [HB-1:0]           req_height_in;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic signed [HB-1:0]           rsp_smoothed_height;
   hbs_pkg::coord_type             rsp_out_col;
   hbs_pkg::coord_type             rsp_out_row;
   logic                           rsp_last_out;
   logic                           csr_wr_en;
   hbs_pkg::csr_idx_type           csr_index;
   logic [hbs_pkg::CSR_DATA_W-1:0] csr_wdata;

   int mismatches, outstanding, live_requests, results_seen;
   int req_idle_pct, rsp_idle_pct, quiet_cycles;
   bit calm, hold_armed;

   heightmap_box_smooth_3x3 #(.MAX_WIDTH(LINE_MAX), .HEIGHT_BITS(HB)) dut (.*);

   hbs_smooth_checker #(.MAX_WIDTH(LINE_MAX), .HEIGHT_BITS(HB)) monitor (.*);

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Ends the run when nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d responses outstanding", $time, outstanding);
         $display("heightmap_box_smooth_3x3 test failed");
         $finish;
      end
   end

   // Response side: random stall bursts, plus one long hold-off when armed.
   initial begin : receiver
      int burst;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_armed) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_armed = 1'b0;
         end else if (!reset && !calm && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_ready <= 1'b0;
            burst = $urandom_range(0, 10);
            repeat (burst) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input hbs_pkg::csr_idx_type idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[hbs_pkg::CSR_DATA_W-1:0];
   endtask

   task automatic csr_close();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic program_region(input int map, input int sc, input int sr,
                                 input int w, input int h);
      csr_write(hbs_pkg::REG_MAP_SIZE, map);
      csr_write(hbs_pkg::REG_START_COL, sc);
      csr_write(hbs_pkg::REG_START_ROW, sr);
      csr_write(hbs_pkg::REG_REGION_WIDTH, w);
      csr_write(hbs_pkg::REG_REGION_HEIGHT, h);
      csr_close();
   endtask

   // Offers count height requests; valid stays high across back-to-back requests.
   task automatic feed(input int count, input bit fixed, input logic [HB-1:0] value);
      logic [HB-1:0] sample;
      int gap;
      for (int i = 0; i < count; i++) begin
         if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
            @(negedge clock);
            req_valid <= 1'b0;
            gap = $urandom_range(0, 10);
            repeat (gap) @(negedge clock);
         end
         if (fixed)
            sample = value;
         else begin
            case ($urandom_range(0, 9))
               0:       sample = HEIGHT_MAX;
               1:       sample = HEIGHT_MIN;
               2, 3, 4: sample = HB'($urandom_range(0, 2047) - 1024);
               default: sample = HB'($urandom);
            endcase
         end
         @(negedge clock);
         req_valid     <= 1'b1;
         req_height_in <= sample;
         do @(posedge clock); while (!req_ready);
      end
   endtask

   // Lets the block drain completely so that registers may be rewritten safely.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int map, sc, sr, w, h, ew, eh, count;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_height_in = '0;
      csr_wr_en     = 1'b0;
      csr_index     = hbs_pkg::REG_MAP_SIZE;
      csr_wdata     = '0;
      calm          = 1'b0;
      hold_armed    = 1'b0;
      req_idle_pct  = 20;
      rsp_idle_pct  = 20;
      quiet_cycles  = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // No map after reset: requests are swallowed.
      feed(2, 1'b1, HEIGHT_MAX);
      settle();
      // Far corner of the largest map, region clamped to 3x3.
      program_region(65535, 65532, 65532, LINE_MAX, 65535);
      feed(9, 1'b1, HEIGHT_MAX);
      settle();
      // Region starting on the map edge produces nothing.
      csr_write(hbs_pkg::REG_START_COL, 65535);
      csr_close();
      feed(2, 1'b1, HEIGHT_MAX);
      settle();
      // Writes to unused indexes must not restart the walk; a real write must.
      program_region(3, 0, 0, 3, 3);
      for (int idx = FIRST_UNUSED_REG; idx < (1 << hbs_pkg::CSR_IDX_W); idx++)
         csr_write(hbs_pkg::csr_idx_type'(idx), $urandom);
      csr_close();
      feed(4, 1'b1, HEIGHT_MIN);
      settle();
      csr_write(hbs_pkg::REG_START_ROW, 0);
      csr_close();
      feed(9, 1'b1, HEIGHT_MIN);
      settle();

      // Three-row pass; the receiver holds off once results flow so the block backs up.
      req_idle_pct = 0;
      rsp_idle_pct = 10;
      program_region(2048, $urandom_range(0, 2048 - PRESS_COLS), $urandom_range(0, 2045),
                     PRESS_COLS, 3);
      feed(2 * PRESS_COLS + 40, 1'b0, '0);
      hold_armed = 1'b1;
      feed(PRESS_COLS - 40, 1'b0, '0);
      settle();

      while (live_requests < ITEMS) begin
         calm = live_requests >= ITEMS - CALM_TAIL;
         case ($urandom_range(0, 2))
            0:       req_idle_pct = 0;
            1:       req_idle_pct = 15;
            default: req_idle_pct = 50;
         endcase
         case ($urandom_range(0, 2))
            0:       rsp_idle_pct = 0;
            1:       rsp_idle_pct = 15;
            default: rsp_idle_pct = 50;
         endcase
         case ($urandom_range(0, 99)) inside
            [0:69]: begin
               case ($urandom_range(0, 4))
                  0, 1, 2: map = $urandom_range(3, 64);
                  3:       map = 65535;
                  default: map = $urandom_range(3, 4000);
               endcase
               if ($urandom_range(0, 3) == 0) begin
                  sc = map - $urandom_range(3, (map < 12) ? map : 12);
                  w  = $urandom_range(map - sc, LINE_MAX);
               end else begin
                  sc = $urandom_range(0, map - 3);
                  w  = $urandom_range(3, 12);
               end
               if ($urandom_range(0, 3) == 0) begin
                  sr = map - $urandom_range(3, (map < 8) ? map : 8);
                  h  = $urandom_range(map - sr, 65535);
               end else begin
                  sr = $urandom_range(0, map - 3);
                  h  = $urandom_range(3, 8);
               end
               ew = (w < map - sc) ? w : map - sc;
               eh = (h < map - sr) ? h : map - sr;
               count = ew * eh * $urandom_range(1, 2);
               // Sometimes leave a pass unfinished so the next programming restarts it.
               if ($urandom_range(0, 4) == 0) count += $urandom_range(1, ew * eh - 1);
            end
            [70:84]: begin
               map = $urandom_range(3, 64);
               sc  = $urandom_range(0, map - 1);
               sr  = $urandom_range(0, map - 1);
               w   = $urandom_range(0, 12);
               h   = $urandom_range(0, 8);
               if ($urandom_range(0, 1)) w = $urandom_range(0, 2);
               else h = $urandom_range(0, 2);
               count = $urandom_range(1, 20);
            end
            default: begin
               map = $urandom_range(1, 64);
               sc  = $urandom_range(0, map - 1);
               sr  = $urandom_range(0, map - 1);
               case ($urandom_range(0, 2))
                  0:       map = 0;
                  1:       sc  = $urandom_range(map, 65535);
                  default: sr  = $urandom_range(map, 65535);
               endcase
               w = $urandom_range(0, LINE_MAX);
               h = $urandom_range(0, 65535);
               count = $urandom_range(1, 10);
            end
         endcase
         program_region(map, sc, sr, w, h);
         if ($urandom_range(0, 9) == 0) begin
            csr_write(hbs_pkg::csr_idx_type'($urandom_range(FIRST_UNUSED_REG,
                                                            (1 << hbs_pkg::CSR_IDX_W) - 1)),
                      $urandom);
            csr_close();
         end
         feed(count, 1'b0, '0);
         settle();
      end

      $display("Covered %0d height requests inside live regions and %0d smoothed responses,",
               live_requests, results_seen);
      $display("including clamped, narrow, empty and off-map regions and a back-pressure pass.");
      if (mismatches == 0 && outstanding == 0)
         $display("heightmap_box_smooth_3x3 test passed");
      else
         $display("heightmap_box_smooth_3x3 test failed");
      $finish;
   end

endmodule
